>>> rtl/core/wrts_pkg.sv
// ----------------------------------------------------------------------------
// wrts_pkg
// Shared types, constants and helpers for the weekly relay time switch.
// ----------------------------------------------------------------------------
package wrts_pkg;

   localparam int RELAY_COUNT  = 4;
   localparam int DAYS         = 7;
   localparam int DAY_SHIFT    = 6;
   localparam int MIN_PER_HOUR = 60;

   localparam int IDX_W    = 3;
   localparam int DAY_W    = 3;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int OUT_W    = 4;

   // minutes of day, up to 31 * 60 + 63
   localparam int MOD_W       = 11;
   localparam int ENTRY_W     = 1 + 2 * MOD_W;
   localparam int TABLE_DEPTH = RELAY_COUNT * DAYS;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int RIDX_W      = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;

   typedef enum logic [1:0] {
      REQ_TICK       = 2'd0,
      REQ_OVR_SET    = 2'd1,
      REQ_OVR_CANCEL = 2'd2,
      REQ_SCHED_WR   = 2'd3
   } req_code_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_READ = 5'b00100,
      ST_EVAL = 5'b01000,
      ST_RESP = 5'b10000
   } wrts_state_type;

   typedef struct packed {
      logic              load;
      logic              exec;
      logic              rd;
      logic              eval;
      logic [RIDX_W-1:0] relay;
   } wrts_cmd_type;

   typedef struct packed {
      logic run_tick;
   } wrts_stat_type;

   function automatic logic [RELAY_COUNT-1:0] relay_mask(input logic [IDX_W-1:0] idx);
      logic [RELAY_COUNT-1:0] m;
      m = '0;
      for (int i = 0; i < RELAY_COUNT; i++) begin
         m[i] = (idx == IDX_W'(i));
      end
      return m;
   endfunction

   function automatic logic [OUT_W-1:0] out_bits(input logic [RELAY_COUNT-1:0] v);
      logic [OUT_W-1:0] r;
      r = '0;
      for (int i = 0; i < OUT_W && i < RELAY_COUNT; i++) begin
         r[i] = v[i];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/wrts_ctrl.sv
// ----------------------------------------------------------------------------
// wrts_ctrl
// Request sequencer: decodes, walks the relays on a synced tick, responds.
// ----------------------------------------------------------------------------
module wrts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wrts_pkg::wrts_stat_type stat,
   output wrts_pkg::wrts_cmd_type  cmd
);
   import wrts_pkg::*;

   wrts_state_type    state_ff, state_in;
   logic [RIDX_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.relay = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in   = '0;
            state_in = stat.run_tick ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (cnt_ff == RIDX_W'(RELAY_COUNT - 1)) begin
               state_in = ST_RESP;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

>>> rtl/core/wrts_dpath.sv
// ----------------------------------------------------------------------------
// wrts_dpath
// Schedule table, relay and override state, window evaluation.
// ----------------------------------------------------------------------------
module wrts_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       req_type,
   input  logic [wrts_pkg::IDX_W-1:0]       req_relay_sel,
   input  logic                             req_turn_on,
   input  logic                             req_time_valid,
   input  logic [wrts_pkg::DAY_W-1:0]       req_weekday,
   input  logic [wrts_pkg::HOUR_W-1:0]      req_hour,
   input  logic [wrts_pkg::MINUTE_W-1:0]    req_minute,
   input  logic                             req_sched_enable,
   input  logic [wrts_pkg::HOUR_W-1:0]      req_off_hr,
   input  logic [wrts_pkg::MINUTE_W-1:0]    req_off_minute,
   input  wrts_pkg::wrts_cmd_type           cmd,
   output wrts_pkg::wrts_stat_type          stat,
   output logic [wrts_pkg::OUT_W-1:0]       rsp_relay_levels,
   output logic [wrts_pkg::OUT_W-1:0]       rsp_override_marks,
   output logic                             rsp_broadcast
);
   import wrts_pkg::*;

   // latched request
   req_code_type        type_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                lvl_ff;
   logic                tvalid_ff;
   logic [DAY_W-1:0]    wday_ff;
   logic [HOUR_W-1:0]   hour_ff;
   logic [MINUTE_W-1:0] minute_ff;
   logic                en_ff;
   logic [HOUR_W-1:0]   ohour_ff;
   logic [MINUTE_W-1:0] ominute_ff;

   // tick context
   logic [MOD_W-1:0] now_ff, now_in;
   logic [DAY_W-1:0] day_ff, day_in;

   logic [RELAY_COUNT-1:0] relay_ff, relay_in;
   logic [RELAY_COUNT-1:0] ovr_ff, ovr_in;
   logic [RELAY_COUNT-1:0] base_ff, base_in;
   logic [RELAY_COUNT-1:0] capt_ff, capt_in;
   logic                   bc_ff, bc_in;

   logic [ENTRY_W-1:0]     tbl_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] tbl_vld_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_vld_ff;

   logic                   in_range;
   logic [RELAY_COUNT-1:0] req_mask;
   logic [RELAY_COUNT-1:0] eval_mask;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [DAY_W:0]         day_sum;
   logic [ENTRY_W-1:0]     entry;
   logic [MOD_W-1:0]       on_mod;
   logic [MOD_W-1:0]       off_mod;
   logic                   sched;
   logic                   cur;
   logic                   nxt;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff    <= req_code_type'(req_type);
         idx_ff     <= req_relay_sel;
         lvl_ff     <= req_turn_on;
         tvalid_ff  <= req_time_valid;
         wday_ff    <= req_weekday;
         hour_ff    <= req_hour;
         minute_ff  <= req_minute;
         en_ff      <= req_sched_enable;
         ohour_ff   <= req_off_hr;
         ominute_ff <= req_off_minute;
      end
      now_ff <= now_in;
      day_ff <= day_in;
   end

   assign stat.run_tick = (type_ff == REQ_TICK) && tvalid_ff;

   assign in_range  = ({1'b0, idx_ff} < (IDX_W + 1)'(RELAY_COUNT));
   assign req_mask  = relay_mask(idx_ff);
   assign eval_mask = relay_mask(IDX_W'(cmd.relay));

   // table holds minutes of day, so a read needs no multiply
   assign wr_en   = cmd.exec && (type_ff == REQ_SCHED_WR) && in_range
                    && (wday_ff < DAY_W'(DAYS));
   assign wr_addr = ADDR_W'(idx_ff) * ADDR_W'(DAYS) + ADDR_W'(wday_ff);
   assign wr_data = {en_ff,
                     MOD_W'(hour_ff) * MOD_W'(MIN_PER_HOUR) + MOD_W'(minute_ff),
                     MOD_W'(ohour_ff) * MOD_W'(MIN_PER_HOUR) + MOD_W'(ominute_ff)};
   assign rd_addr = ADDR_W'(cmd.relay) * ADDR_W'(DAYS) + ADDR_W'(day_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            tbl_vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd) begin
            rd_vld_ff <= tbl_vld_ff[rd_addr];
         end
      end
   end

   // never written entries read as disabled windows
   assign entry   = rd_vld_ff ? rd_data_ff : '0;
   assign on_mod  = entry[2*MOD_W-1:MOD_W];
   assign off_mod = entry[MOD_W-1:0];
   always_comb begin
      if (!entry[ENTRY_W-1]) begin
         sched = 1'b0;
      end else if (on_mod < off_mod) begin
         sched = (now_ff >= on_mod) && (now_ff < off_mod);
      end else begin
         sched = (now_ff >= on_mod) || (now_ff < off_mod);
      end
   end

   // sunday-based weekday to monday-based table day
   assign day_sum = {1'b0, wday_ff} + (DAY_W + 1)'(DAY_SHIFT);

   always_comb begin
      relay_in = relay_ff;
      ovr_in   = ovr_ff;
      base_in  = base_ff;
      capt_in  = capt_ff;
      bc_in    = bc_ff;
      now_in   = now_ff;
      day_in   = day_ff;
      cur      = |(relay_ff & eval_mask);
      nxt      = cur;
      if (cmd.exec) begin
         bc_in  = 1'b0;
         now_in = MOD_W'(hour_ff) * MOD_W'(MIN_PER_HOUR) + MOD_W'(minute_ff);
         day_in = (day_sum >= (DAY_W + 1)'(DAYS)) ? DAY_W'(day_sum - (DAY_W + 1)'(DAYS))
                                                  : DAY_W'(day_sum);
         case (type_ff)
            REQ_OVR_SET: begin
               if (in_range) begin
                  ovr_in   = ovr_ff | req_mask;
                  capt_in  = capt_ff & ~req_mask;
                  relay_in = lvl_ff ? (relay_ff | req_mask) : (relay_ff & ~req_mask);
                  bc_in    = 1'b1;
               end
            end
            REQ_OVR_CANCEL: begin
               if (in_range) begin
                  ovr_in = ovr_ff & ~req_mask;
                  bc_in  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.eval) begin
         if (|(ovr_ff & eval_mask)) begin
            if (!(|(capt_ff & eval_mask))) begin
               base_in = sched ? (base_ff | eval_mask) : (base_ff & ~eval_mask);
               capt_in = capt_ff | eval_mask;
            end else if (sched != (|(base_ff & eval_mask))) begin
               ovr_in = ovr_ff & ~eval_mask;
               nxt    = sched;
            end
         end else begin
            nxt = sched;
         end
         relay_in = nxt ? (relay_ff | eval_mask) : (relay_ff & ~eval_mask);
         if (nxt != cur) begin
            bc_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff <= '0;
         ovr_ff   <= '0;
         base_ff  <= '0;
         capt_ff  <= '0;
         bc_ff    <= 1'b0;
      end else begin
         relay_ff <= relay_in;
         ovr_ff   <= ovr_in;
         base_ff  <= base_in;
         capt_ff  <= capt_in;
         bc_ff    <= bc_in;
      end
   end

   assign rsp_relay_levels   = out_bits(relay_ff);
   assign rsp_override_marks = out_bits(ovr_ff);
   assign rsp_broadcast      = bc_ff;

endmodule

>>> rtl/core/weekly_relay_time_switch.sv
// ----------------------------------------------------------------------------
// weekly_relay_time_switch
// Weekly programmable relay switch with manual override.
//
//   channel   direction  handshake             ports
//   request   in         start & !busy         req_*
//   response  out        rsp_valid, one cycle  rsp_*
//
// Override, schedule write and unsynced tick requests pass through EXEC and RESP
// back to idle; a synced tick also walks READ then EVAL for each relay in turn,
// set by the single table read port: each relay's window is read, then evaluated.
// The response is shown in the cycle before busy falls; the receiver cannot stall.
// Synchronous reset clears relay and override state and marks the table empty.
// ----------------------------------------------------------------------------
module weekly_relay_time_switch (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [wrts_pkg::IDX_W-1:0]    req_relay_sel,
   input  logic                          req_turn_on,
   input  logic                          req_time_valid,
   input  logic [wrts_pkg::DAY_W-1:0]    req_weekday,
   input  logic [wrts_pkg::HOUR_W-1:0]   req_hour,
   input  logic [wrts_pkg::MINUTE_W-1:0] req_minute,
   input  logic                          req_sched_enable,
   input  logic [wrts_pkg::HOUR_W-1:0]   req_off_hr,
   input  logic [wrts_pkg::MINUTE_W-1:0] req_off_minute,
   output logic                          rsp_valid,
   output logic [wrts_pkg::OUT_W-1:0]    rsp_relay_levels,
   output logic [wrts_pkg::OUT_W-1:0]    rsp_override_marks,
   output logic                          rsp_broadcast
);
   import wrts_pkg::*;

   wrts_cmd_type  cmd;
   wrts_stat_type stat;

   wrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   wrts_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_relay_sel      (req_relay_sel),
      .req_turn_on        (req_turn_on),
      .req_time_valid     (req_time_valid),
      .req_weekday        (req_weekday),
      .req_hour           (req_hour),
      .req_minute         (req_minute),
      .req_sched_enable   (req_sched_enable),
      .req_off_hr         (req_off_hr),
      .req_off_minute     (req_off_minute),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_relay_levels   (rsp_relay_levels),
      .rsp_override_marks (rsp_override_marks),
      .rsp_broadcast      (rsp_broadcast)
   );

endmodule

>>> tb/tb_weekly_relay_time_switch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weekly_relay_time_switch
// Self-checking bench for the weekly relay time switch. A directed sequence
// covers window shapes, ignored requests and the override life cycle, then
// random requests walk a local clock forward through random weekly tables.
// Every accepted request is predicted and each response strobe is checked.
// ----------------------------------------------------------------------------
module tb_weekly_relay_time_switch;

   import wrts_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 2 * (3 + 2 * RELAY_COUNT);
   localparam int RANDOM_ITEMS  = 600;
   localparam int MIN_PER_DAY   = 24 * MIN_PER_HOUR;

   typedef struct {
      req_code_type        kind;
      logic [IDX_W-1:0]    relay_sel;
      logic                turn_on;
      logic                time_valid;
      logic [DAY_W-1:0]    weekday;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic                sched_enable;
      logic [HOUR_W-1:0]   off_hr;
      logic [MINUTE_W-1:0] off_minute;
   } switch_request_type;

   typedef struct packed {
      logic                enable;
      logic [HOUR_W-1:0]   on_hour;
      logic [MINUTE_W-1:0] on_minute;
      logic [HOUR_W-1:0]   off_hr;
      logic [MINUTE_W-1:0] off_minute;
   } day_window_type;

   typedef struct {
      logic [OUT_W-1:0] relay_levels;
      logic [OUT_W-1:0] override_marks;
      logic             broadcast;
   } relay_status_type;

   class relay_switch_predictor;
      day_window_type         week_table [RELAY_COUNT][DAYS];
      logic [RELAY_COUNT-1:0] relay_on;
      logic [RELAY_COUNT-1:0] override_on;
      logic [RELAY_COUNT-1:0] base_level;
      logic [RELAY_COUNT-1:0] base_taken;
      relay_status_type       pending_status [$];
      int                     error_count;

      function new();
         foreach (week_table[r, d]) week_table[r][d] = '0;
         relay_on    = '0;
         override_on = '0;
         base_level  = '0;
         base_taken  = '0;
         error_count = 0;
      endfunction

      function bit window_active(day_window_type w, int now);
         int on_mod;
         int off_mod;
         if (!w.enable) return 1'b0;
         on_mod  = int'(w.on_hour) * MIN_PER_HOUR + int'(w.on_minute);
         off_mod = int'(w.off_hr) * MIN_PER_HOUR + int'(w.off_minute);
         if (on_mod < off_mod) return (now >= on_mod) && (now < off_mod);
         // window wraps past midnight, or spans the whole day when on equals off
         return (now >= on_mod) || (now < off_mod);
      endfunction

      function bit run_tick(logic [DAY_W-1:0] wday, logic [HOUR_W-1:0] hr,
                            logic [MINUTE_W-1:0] mn);
         int day;
         int now;
         bit changed;
         bit sched;
         bit cur;
         bit nxt;
         // tick weekday counts from sunday, the table from monday
         day     = (int'(wday) + DAY_SHIFT) % DAYS;
         now     = int'(hr) * MIN_PER_HOUR + int'(mn);
         changed = 1'b0;
         for (int i = 0; i < RELAY_COUNT; i++) begin
            sched = window_active(week_table[i][day], now);
            cur   = relay_on[i];
            nxt   = cur;
            if (override_on[i]) begin
               if (!base_taken[i]) begin
                  base_level[i] = sched;
                  base_taken[i] = 1'b1;
               end else if (sched != base_level[i]) begin
                  override_on[i] = 1'b0;
                  nxt = sched;
               end
            end else begin
               nxt = sched;
            end
            if (nxt != cur) begin
               relay_on[i] = nxt;
               changed = 1'b1;
            end
         end
         return changed;
      endfunction

      function void note_request(switch_request_type rq);
         bit                     bcast;
         bit                     in_range;
         logic [RELAY_COUNT-1:0] sel;
         relay_status_type       st;
         bcast    = 1'b0;
         in_range = int'(rq.relay_sel) < RELAY_COUNT;
         sel      = '0;
         if (in_range) sel[rq.relay_sel] = 1'b1;
         case (rq.kind)
            REQ_TICK: begin
               if (rq.time_valid) bcast = run_tick(rq.weekday, rq.hour, rq.minute);
            end
            REQ_OVR_SET: begin
               if (in_range) begin
                  override_on = override_on | sel;
                  base_taken  = base_taken & ~sel;
                  relay_on    = rq.turn_on ? (relay_on | sel) : (relay_on & ~sel);
                  bcast       = 1'b1;
               end
            end
            REQ_OVR_CANCEL: begin
               if (in_range) begin
                  override_on = override_on & ~sel;
                  bcast       = 1'b1;
               end
            end
            default: begin
               if (in_range && int'(rq.weekday) < DAYS) begin
                  week_table[rq.relay_sel][rq.weekday] = '{rq.sched_enable, rq.hour,
                     rq.minute, rq.off_hr, rq.off_minute};
               end
            end
         endcase
         st.relay_levels   = OUT_W'(32'(relay_on));
         st.override_marks = OUT_W'(32'(override_on));
         st.broadcast      = bcast;
         pending_status.push_back(st);
      endfunction

      function void check_response(logic [OUT_W-1:0] levels, logic [OUT_W-1:0] marks,
                                   logic bcast);
         relay_status_type exp_st;
         if (pending_status.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
            return;
         end
         exp_st = pending_status.pop_front();
         if (levels !== exp_st.relay_levels) begin
            $error("relay_levels: expected %h, actual %h", exp_st.relay_levels, levels);
            error_count++;
         end
         if (marks !== exp_st.override_marks) begin
            $error("override_marks: expected %h, actual %h", exp_st.override_marks, marks);
            error_count++;
         end
         if (bcast !== exp_st.broadcast) begin
            $error("broadcast: expected %b, actual %b", exp_st.broadcast, bcast);
            error_count++;
         end
      endfunction

      function void report_leftover();
         if (pending_status.size() != 0) begin
            $error("%0d responses never arrived", pending_status.size());
            error_count += pending_status.size();
         end
      endfunction
   endclass

   logic                clock;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [1:0]          req_type         = '0;
   logic [IDX_W-1:0]    req_relay_sel    = '0;
   logic                req_turn_on      = 1'b0;
   logic                req_time_valid   = 1'b0;
   logic [DAY_W-1:0]    req_weekday      = '0;
   logic [HOUR_W-1:0]   req_hour         = '0;
   logic [MINUTE_W-1:0] req_minute       = '0;
   logic                req_sched_enable = 1'b0;
   logic [HOUR_W-1:0]   req_off_hr       = '0;
   logic [MINUTE_W-1:0] req_off_minute   = '0;
   logic                rsp_valid;
   logic [OUT_W-1:0]    rsp_relay_levels;
   logic [OUT_W-1:0]    rsp_override_marks;
   logic                rsp_broadcast;

   relay_switch_predictor predictor;

   // local time walked forward by the random ticks
   int walk_day    = 0;
   int walk_minute = 0;

   weekly_relay_time_switch dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_relay_sel      (req_relay_sel),
      .req_turn_on        (req_turn_on),
      .req_time_valid     (req_time_valid),
      .req_weekday        (req_weekday),
      .req_hour           (req_hour),
      .req_minute         (req_minute),
      .req_sched_enable   (req_sched_enable),
      .req_off_hr         (req_off_hr),
      .req_off_minute     (req_off_minute),
      .rsp_valid          (rsp_valid),
      .rsp_relay_levels   (rsp_relay_levels),
      .rsp_override_marks (rsp_override_marks),
      .rsp_broadcast      (rsp_broadcast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         predictor.check_response(rsp_relay_levels, rsp_override_marks, rsp_broadcast);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   function automatic switch_request_type build_request(
      req_code_type kind, int idx, int on, int valid, int wd, int hr, int mn,
      int en, int ohr, int omn);
      switch_request_type rq;
      rq.kind         = kind;
      rq.relay_sel    = IDX_W'(idx);
      rq.turn_on      = 1'(on);
      rq.time_valid   = 1'(valid);
      rq.weekday      = DAY_W'(wd);
      rq.hour         = HOUR_W'(hr);
      rq.minute       = MINUTE_W'(mn);
      rq.sched_enable = 1'(en);
      rq.off_hr       = HOUR_W'(ohr);
      rq.off_minute   = MINUTE_W'(omn);
      return rq;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(4, 1);
      return $urandom_range(50, 10);
   endfunction

   task automatic make_random_request(output switch_request_type rq);
      int sel;
      sel = $urandom_range(99);
      // every field starts as full-width noise
      rq.kind         = req_code_type'(2'($urandom_range(3)));
      rq.relay_sel    = IDX_W'($urandom_range(7));
      rq.turn_on      = 1'($urandom_range(1));
      rq.time_valid   = 1'($urandom_range(1));
      rq.weekday      = DAY_W'($urandom_range(7));
      rq.hour         = HOUR_W'($urandom_range(31));
      rq.minute       = MINUTE_W'($urandom_range(63));
      rq.sched_enable = 1'($urandom_range(1));
      rq.off_hr       = HOUR_W'($urandom_range(31));
      rq.off_minute   = MINUTE_W'($urandom_range(63));
      if (sel < 50) begin
         rq.kind       = REQ_TICK;
         rq.time_valid = ($urandom_range(9) != 0);
         if ($urandom_range(19) != 0) begin
            walk_minute += $urandom_range(240);
            if (walk_minute >= MIN_PER_DAY) begin
               walk_minute -= MIN_PER_DAY;
               walk_day = (walk_day + 1) % DAYS;
            end
            rq.weekday = DAY_W'(walk_day);
            // weekday 7 aliases to sunday
            if (walk_day == 6 && $urandom_range(1) == 1) rq.weekday = DAY_W'(7);
            rq.hour   = HOUR_W'(walk_minute / MIN_PER_HOUR);
            rq.minute = MINUTE_W'(walk_minute % MIN_PER_HOUR);
         end
      end else if (sel < 75) begin
         rq.kind = REQ_SCHED_WR;
         if ($urandom_range(9) != 0) rq.relay_sel = IDX_W'($urandom_range(RELAY_COUNT - 1));
         if ($urandom_range(9) != 0) rq.weekday = DAY_W'($urandom_range(DAYS - 1));
         rq.sched_enable = ($urandom_range(4) != 0);
         if ($urandom_range(9) != 0) begin
            rq.hour       = HOUR_W'($urandom_range(23));
            rq.minute     = MINUTE_W'($urandom_range(59));
            rq.off_hr     = HOUR_W'($urandom_range(23));
            rq.off_minute = MINUTE_W'($urandom_range(59));
         end
      end else begin
         rq.kind = (sel < 90) ? REQ_OVR_SET : REQ_OVR_CANCEL;
         if ($urandom_range(7) != 0) rq.relay_sel = IDX_W'($urandom_range(RELAY_COUNT - 1));
      end
   endtask

   task automatic send_request(input switch_request_type rq);
      @(negedge clock);
      start            <= 1'b1;
      req_type         <= rq.kind;
      req_relay_sel    <= rq.relay_sel;
      req_turn_on      <= rq.turn_on;
      req_time_valid   <= rq.time_valid;
      req_weekday      <= rq.weekday;
      req_hour         <= rq.hour;
      req_minute       <= rq.minute;
      req_sched_enable <= rq.sched_enable;
      req_off_hr       <= rq.off_hr;
      req_off_minute   <= rq.off_minute;
      do @(posedge clock); while (busy);
      predictor.note_request(rq);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   initial begin : main
      switch_request_type directed_list [$];
      switch_request_type rq;
      predictor = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: unsynced then synced tick
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 0, 3, 12, 30, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 3, 12, 30, 0, 0, 0));
      // plain, wrapping, on equal to off, full day and top field values
      directed_list.push_back(build_request(REQ_SCHED_WR, 0, 0, 0, 0, 8, 0, 1, 17, 0));
      directed_list.push_back(build_request(REQ_SCHED_WR, 1, 0, 0, 0, 22, 0, 1, 6, 0));
      directed_list.push_back(build_request(REQ_SCHED_WR, 2, 0, 0, 6, 0, 0, 1, 0, 0));
      directed_list.push_back(build_request(REQ_SCHED_WR, 3, 0, 0, 0, 0, 0, 1, 23, 59));
      directed_list.push_back(build_request(REQ_SCHED_WR, 3, 1, 1, 6, 31, 63, 1, 31, 63));
      // relay out of range and table day 7 are dropped
      directed_list.push_back(build_request(REQ_SCHED_WR, 7, 1, 1, 0, 1, 1, 1, 2, 2));
      directed_list.push_back(build_request(REQ_SCHED_WR, 0, 1, 1, 7, 1, 1, 1, 2, 2));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 1, 9, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 1, 23, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 0, 12, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 7, 1, 1, 7, 12, 0, 1, 31, 63));
      // override: capture base, hold, then cancel on schedule edge
      directed_list.push_back(build_request(REQ_OVR_SET, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_OVR_SET, 5, 1, 1, 7, 31, 63, 1, 31, 63));
      directed_list.push_back(build_request(REQ_OVR_CANCEL, 6, 1, 1, 7, 31, 63, 1, 31, 63));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 1, 7, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 1, 7, 30, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 1, 8, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_OVR_SET, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_OVR_CANCEL, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 0, 1, 23, 0, 0, 0, 0));
      directed_list.push_back(build_request(REQ_TICK, 0, 0, 1, 1, 31, 63, 0, 0, 0));
      directed_list.push_back(build_request(REQ_OVR_SET, 3, 0, 1, 7, 31, 63, 1, 31, 63));

      foreach (directed_list[k]) begin
         send_request(directed_list[k]);
         idle_gap(pick_gap());
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         make_random_request(rq);
         send_request(rq);
         // every 150 requests a burst runs back to back
         idle_gap(((n % 150) < 30) ? 0 : pick_gap());
      end

      @(negedge clock);
      start <= 1'b0;
      while (predictor.pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      predictor.report_leftover();
      if (predictor.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/wrts_pkg.sv
rtl/core/wrts_ctrl.sv
rtl/core/wrts_dpath.sv
rtl/core/weekly_relay_time_switch.sv
tb/tb_weekly_relay_time_switch.sv
